### sv/rrtt_pkg.sv
// Package for the round-robin task table: shared types, codes and sizing constants.
// Used by the top level, rrtt_ctrl and rrtt_datapath; depends on nothing.
`timescale 1ns / 1ps

package rrtt_pkg;

   // default table size and the number of slots examined per search cycle
   localparam int SLOT_COUNT_DEF = 16;
   localparam int SCAN_LANES     = 16;

   // widths fixed by the request and response fields
   localparam int ACTION_W = 2;
   localparam int SP_W     = 64;
   localparam int ID_W     = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INIT  = 2'd0,
      ACT_SPAWN = 2'd1,
      ACT_EXIT  = 2'd2,
      ACT_YIELD = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_READY      = 2'd0,
      ST_RUNNING    = 2'd1,
      ST_TERMINATED = 2'd2
   } slot_status_type;

   // status change applied in the cycle a request is taken
   typedef enum logic [2:0] {
      PREP_NONE   = 3'd0,
      PREP_INIT   = 3'd1,
      PREP_SPAWN0 = 3'd2,
      PREP_TERM   = 3'd3,
      PREP_DEMOTE = 3'd4
   } prep_op_type;

   // what the slot search looks for
   typedef enum logic [1:0] {
      SRCH_FREE  = 2'd0,
      SRCH_TERM  = 2'd1,
      SRCH_READY = 2'd2
   } srch_mode_type;

   typedef struct packed {
      logic          load;
      prep_op_type   prep;
      srch_mode_type mode;
      logic          step;
      logic          restart;
      logic          commit;
   } dp_cmd_type;

   typedef struct packed {
      logic has_current;
      logic cur_live;
      logic hit;
      logic last_chunk;
   } dp_status_type;

endpackage

### sv/round_robin_task_table.sv
// Top level of the round-robin task table: joins the controller and the datapath.
// Depends on rrtt_pkg, rrtt_ctrl, rrtt_datapath and rrtt_search.
//
// Usage: drive req_action, req_new_stack_sp and req_kernel_sp with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Busy stays high until the response has been shown. The response is on the
// rsp_ ports for exactly one cycle with rsp_valid high; the receiver cannot
// stall it, so it must capture it in that cycle.
// The response follows the accepting edge, after the slot search where one is run;
// a new request can be taken right after the response.
// Init, spawn without a current task and exit without a live current task run no search.
// Exit and yield search the ready slots; spawn searches the free slots and then,
// if none is free, the terminated slots. Each pass examines up to 16 slots per chunk
// and stops at the chunk holding the first match. A reschedule also
// reads the chosen slot's stack from the stack memory, whose registered read
// overlaps the response cycle.
// Reset clears the used bits and the current task; no clearing pass is run.
`timescale 1ns / 1ps

module round_robin_task_table #(
   parameter int SLOT_COUNT = rrtt_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rrtt_pkg::ACTION_W-1:0] req_action,
   input  logic [rrtt_pkg::SP_W-1:0]     req_new_stack_sp,
   input  logic [rrtt_pkg::SP_W-1:0]     req_kernel_sp,
   output logic                          rsp_valid,
   output logic                          rsp_spawn_ok,
   output logic [rrtt_pkg::ID_W-1:0]     rsp_new_task_id,
   output logic                          rsp_switch_valid,
   output logic [rrtt_pkg::SP_W-1:0]     rsp_switch_sp,
   output logic                          rsp_current_valid,
   output logic [rrtt_pkg::ID_W-1:0]     rsp_current_id
);

   rrtt_pkg::dp_cmd_type    cmd;
   rrtt_pkg::dp_status_type status;

   // sequencing of each request
   rrtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_action),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // slot table, stack memory and search
   rrtt_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_new_stack_sp  (req_new_stack_sp),
      .req_kernel_sp     (req_kernel_sp),
      .rsp_spawn_ok      (rsp_spawn_ok),
      .rsp_new_task_id   (rsp_new_task_id),
      .rsp_switch_valid  (rsp_switch_valid),
      .rsp_switch_sp     (rsp_switch_sp),
      .rsp_current_valid (rsp_current_valid),
      .rsp_current_id    (rsp_current_id)
   );

endmodule

### sv/rrtt_ctrl.sv
// Controller state machine of the round-robin task table.
// Depends on rrtt_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps

module rrtt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rrtt_pkg::ACTION_W-1:0] action,
   input  rrtt_pkg::dp_status_type      status,
   output rrtt_pkg::dp_cmd_type         cmd,
   output logic                         busy,
   output logic                         rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   rrtt_pkg::srch_mode_type mode_ff, mode_in;
   rrtt_pkg::action_type    act;

   assign act       = rrtt_pkg::action_type'(action);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cmd         = '0;
      cmd.prep    = rrtt_pkg::PREP_NONE;
      cmd.mode    = mode_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (act)
                  rrtt_pkg::ACT_INIT: begin
                     cmd.prep = rrtt_pkg::PREP_INIT;
                     state_in = S_RESP;
                  end
                  rrtt_pkg::ACT_SPAWN: begin
                     if (!status.has_current) begin
                        cmd.prep = rrtt_pkg::PREP_SPAWN0;
                        state_in = S_RESP;
                     end else begin
                        mode_in  = rrtt_pkg::SRCH_FREE;
                        state_in = S_SCAN;
                     end
                  end
                  rrtt_pkg::ACT_EXIT: begin
                     if (status.cur_live) begin
                        cmd.prep = rrtt_pkg::PREP_TERM;
                        mode_in  = rrtt_pkg::SRCH_READY;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     cmd.prep = rrtt_pkg::PREP_DEMOTE;
                     mode_in  = rrtt_pkg::SRCH_READY;
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (status.hit) begin
               cmd.commit = 1'b1;
               state_in   = S_RESP;
            end else if (status.last_chunk) begin
               // no match in any chunk: a free-slot search falls back to terminated slots
               if (mode_ff == rrtt_pkg::SRCH_FREE) begin
                  mode_in     = rrtt_pkg::SRCH_TERM;
                  cmd.restart = 1'b1;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= rrtt_pkg::SRCH_FREE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

### sv/rrtt_search.sv
// Circular slot search: examines one chunk of lanes per cycle and returns the first match.
// Depends on nothing but its parameters; used by rrtt_datapath.
`timescale 1ns / 1ps

module rrtt_search #(
   parameter int SLOT_COUNT = 16,
   parameter int LANES      = 16,
   localparam int IDX_W     = $clog2(SLOT_COUNT),
   localparam int CHUNKS    = (SLOT_COUNT + LANES - 1) / LANES,
   localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
   input  logic [SLOT_COUNT-1:0] vec,
   input  logic [IDX_W-1:0]      start_idx,
   input  logic [CHUNK_W-1:0]    chunk,
   output logic                  hit,
   output logic [IDX_W-1:0]      hit_idx
);

   localparam int SUM_W = IDX_W + 2;

   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] lane_k [LANES];
   logic [SUM_W-1:0] lane_s [LANES];
   logic [IDX_W-1:0] lane_idx [LANES];
   logic [LANES-1:0] hits;
   logic [LANES-1:0] first;

   assign base = SUM_W'(chunk) * SUM_W'(LANES);

   // per lane: position in circular order, wrapped slot index and match
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         lane_k[j] = base + SUM_W'(j);
         lane_s[j] = SUM_W'(start_idx) + lane_k[j];
         if (lane_s[j] >= SUM_W'(SLOT_COUNT)) begin
            lane_s[j] = lane_s[j] - SUM_W'(SLOT_COUNT);
         end
         lane_idx[j] = IDX_W'(lane_s[j]);
         hits[j]     = (lane_k[j] < SUM_W'(SLOT_COUNT)) && vec[lane_idx[j]];
      end
   end

   // lowest matching lane comes first in circular order
   assign first = hits & (~hits + LANES'(1));
   assign hit   = |hits;

   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < LANES; j++) begin
         if (first[j]) begin
            hit_idx = hit_idx | lane_idx[j];
         end
      end
   end

endmodule

### sv/rrtt_datapath.sv
// Datapath of the round-robin task table: slot flags, stack memory, search and results.
// Depends on rrtt_pkg and rrtt_search; controlled by rrtt_ctrl.
`timescale 1ns / 1ps

module rrtt_datapath #(
   parameter int SLOT_COUNT = rrtt_pkg::SLOT_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rrtt_pkg::dp_cmd_type     cmd,
   output rrtt_pkg::dp_status_type  status,
   input  logic [rrtt_pkg::SP_W-1:0] req_new_stack_sp,
   input  logic [rrtt_pkg::SP_W-1:0] req_kernel_sp,
   output logic                     rsp_spawn_ok,
   output logic [rrtt_pkg::ID_W-1:0] rsp_new_task_id,
   output logic                     rsp_switch_valid,
   output logic [rrtt_pkg::SP_W-1:0] rsp_switch_sp,
   output logic                     rsp_current_valid,
   output logic [rrtt_pkg::ID_W-1:0] rsp_current_id
);

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int LANES   = (SLOT_COUNT < rrtt_pkg::SCAN_LANES) ? SLOT_COUNT
                                                               : rrtt_pkg::SCAN_LANES;
   localparam int CHUNKS  = (SLOT_COUNT + LANES - 1) / LANES;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int SP_W    = rrtt_pkg::SP_W;

   // slot table and scheduler state
   logic [SLOT_COUNT-1:0]     used_ff, used_in;
   rrtt_pkg::slot_status_type status_ff [SLOT_COUNT];
   rrtt_pkg::slot_status_type status_in [SLOT_COUNT];
   logic                      has_ff, has_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [SP_W-1:0]           stack_mem_ff [SLOT_COUNT];
   logic [SP_W-1:0]           rd_ff;

   // request copies and result flags
   logic [SP_W-1:0]    new_sp_ff, ksp_ff;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   new_id_ff, new_id_in;
   logic               swv_ff, swv_in;
   logic               bypass_ff, bypass_in;

   // memory port
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr;
   logic [SP_W-1:0]  mem_wdata;

   logic                      cur_live, cur_running, save_ok;
   rrtt_pkg::slot_status_type cur_status;
   logic [SLOT_COUNT-1:0]     srch_vec;
   logic [IDX_W-1:0]          srch_start;
   logic                      hit;
   logic [IDX_W-1:0]          hit_idx;
   logic                      commit_switch, commit_spawn;

   assign cur_status  = status_ff[cur_ff];
   assign cur_live    = has_ff && used_ff[cur_ff];
   assign cur_running = cur_live && (cur_status == rrtt_pkg::ST_RUNNING);
   assign save_ok     = cur_live && (cur_status != rrtt_pkg::ST_TERMINATED)
                        && (ksp_ff != '0);

   assign commit_switch = cmd.commit && (cmd.mode == rrtt_pkg::SRCH_READY);
   assign commit_spawn  = cmd.commit && (cmd.mode != rrtt_pkg::SRCH_READY);

   // candidate vector for the current search
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         case (cmd.mode)
            rrtt_pkg::SRCH_FREE:  srch_vec[i] = !used_ff[i];
            rrtt_pkg::SRCH_TERM:  srch_vec[i] = (status_ff[i] == rrtt_pkg::ST_TERMINATED);
            rrtt_pkg::SRCH_READY: srch_vec[i] = used_ff[i]
                                                && (status_ff[i] == rrtt_pkg::ST_READY);
            default:              srch_vec[i] = 1'b0;
         endcase
      end
   end

   // reschedule starts after the current slot (at slot 0 without one), spawn searches start at slot 0
   always_comb begin
      srch_start = '0;
      if ((cmd.mode == rrtt_pkg::SRCH_READY) && has_ff) begin
         if (cur_ff == IDX_W'(SLOT_COUNT - 1)) begin
            srch_start = '0;
         end else begin
            srch_start = cur_ff + IDX_W'(1);
         end
      end
   end

   rrtt_search #(
      .SLOT_COUNT (SLOT_COUNT),
      .LANES      (LANES)
   ) u_search (
      .vec       (srch_vec),
      .start_idx (srch_start),
      .chunk     (chunk_ff),
      .hit       (hit),
      .hit_idx   (hit_idx)
   );

   assign status.has_current = has_ff;
   assign status.cur_live    = cur_live;
   assign status.hit         = hit;
   assign status.last_chunk  = (chunk_ff == CHUNK_W'(CHUNKS - 1));

   // slot table update
   always_comb begin
      used_in = used_ff;
      has_in  = has_ff;
      cur_in  = cur_ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         status_in[i] = status_ff[i];
      end
      case (cmd.prep)
         rrtt_pkg::PREP_INIT: begin
            used_in      = '0;
            used_in[0]   = 1'b1;
            status_in[0] = rrtt_pkg::ST_RUNNING;
            has_in       = 1'b1;
            cur_in       = '0;
         end
         rrtt_pkg::PREP_SPAWN0: begin
            used_in[0]   = 1'b1;
            status_in[0] = rrtt_pkg::ST_READY;
         end
         rrtt_pkg::PREP_TERM: begin
            status_in[cur_ff] = rrtt_pkg::ST_TERMINATED;
         end
         rrtt_pkg::PREP_DEMOTE: begin
            if (cur_running) begin
               status_in[cur_ff] = rrtt_pkg::ST_READY;
            end
         end
         default: begin
         end
      endcase
      if (commit_switch) begin
         status_in[hit_idx] = rrtt_pkg::ST_RUNNING;
         cur_in             = hit_idx;
         has_in             = 1'b1;
      end
      if (commit_spawn) begin
         used_in[hit_idx]   = 1'b1;
         status_in[hit_idx] = rrtt_pkg::ST_READY;
         if (cur_running && (hit_idx != cur_ff)) begin
            status_in[cur_ff] = rrtt_pkg::ST_READY;
         end
      end
   end

   // stack memory write and read selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = commit_switch;
      if (cmd.prep == rrtt_pkg::PREP_INIT) begin
         mem_we = 1'b1;
      end else if (cmd.prep == rrtt_pkg::PREP_SPAWN0) begin
         mem_we    = 1'b1;
         mem_wdata = req_new_stack_sp;
      end else if (commit_spawn) begin
         mem_we    = 1'b1;
         mem_waddr = hit_idx;
         mem_wdata = new_sp_ff;
      end else if (commit_switch && save_ok) begin
         mem_we    = 1'b1;
         mem_waddr = cur_ff;
         mem_wdata = ksp_ff;
      end
   end

   // search position and result flags
   always_comb begin
      chunk_in  = chunk_ff;
      ok_in     = ok_ff;
      new_id_in = new_id_ff;
      swv_in    = swv_ff;
      bypass_in = bypass_ff;
      if (cmd.load || cmd.restart) begin
         chunk_in = '0;
      end else if (cmd.step) begin
         chunk_in = chunk_ff + CHUNK_W'(1);
      end
      if (cmd.load) begin
         ok_in     = 1'b0;
         new_id_in = '0;
         swv_in    = 1'b0;
         bypass_in = 1'b0;
      end
      if (cmd.prep == rrtt_pkg::PREP_SPAWN0) begin
         ok_in = 1'b1;
      end
      if (commit_spawn) begin
         ok_in     = 1'b1;
         new_id_in = hit_idx;
      end
      // a switch sets the valid flag; bypass when the chosen slot is the current one and its stack is being saved now
      if (commit_switch) begin
         swv_in    = 1'b1;
         bypass_in = save_ok && (hit_idx == cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         has_ff    <= 1'b0;
         cur_ff    <= '0;
         chunk_ff  <= '0;
         ok_ff     <= 1'b0;
         new_id_ff <= '0;
         swv_ff    <= 1'b0;
         bypass_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         has_ff    <= has_in;
         cur_ff    <= cur_in;
         chunk_ff  <= chunk_in;
         ok_ff     <= ok_in;
         new_id_ff <= new_id_in;
         swv_ff    <= swv_in;
         bypass_ff <= bypass_in;
      end
   end

   // status and request copies carry no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         status_ff[i] <= status_in[i];
      end
      if (cmd.load) begin
         new_sp_ff <= req_new_stack_sp;
         ksp_ff    <= req_kernel_sp;
      end
   end

   // saved stack memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= stack_mem_ff[hit_idx];
      end
   end

   // response fields
   assign rsp_spawn_ok      = ok_ff;
   assign rsp_new_task_id   = (rrtt_pkg::ID_W)'(new_id_ff);
   assign rsp_switch_valid  = swv_ff;
   assign rsp_switch_sp     = swv_ff ? (bypass_ff ? ksp_ff : rd_ff) : '0;
   assign rsp_current_valid = has_ff;
   assign rsp_current_id    = has_ff ? (rrtt_pkg::ID_W)'(cur_ff) : '0;

endmodule
